/* src/assert_macros.svh */
// Assertion helpers included by linear_queue_with_reverse.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

/* src/lqr_pkg.sv */
`default_nettype none

package lqr_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;
    localparam int REQ_W   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ       = 3'd0,
        REQ_DEQ       = 3'd1,
        REQ_PEEK_HEAD = 3'd2,
        REQ_PEEK_TAIL = 3'd3,
        REQ_REVERSE   = 3'd4,
        REQ_CLEAR     = 3'd5
    } t_req;

endpackage

`default_nettype wire

/* src/lqr_ram.sv */
`default_nettype none

module lqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

/* src/linear_queue_with_reverse.sv */
// Enqueue, clear, reverse of zero or one entry, failed requests: result in the next cycle.
// Dequeue and peeks: S_RD waits for the registered store read, then loads the result.
// Reverse of n entries: floor(n/2) swaps on the store, each through S_SWAP_RD then S_SWAP_WR.
// Throughput: one enqueue per cycle while each result is taken; store reads block new requests.
// Reset: i_rst_n synchronous, active low; clears head, tail, state and output valid.
// Reset: the store is not cleared; entries become reachable only after being written.
`default_nettype none

`include "assert_macros.svh"

module linear_queue_with_reverse #(
    parameter int DEPTH = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lqr_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic signed [lqr_pkg::DATA_W-1:0] i_data_in,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_ok,
    output logic signed [lqr_pkg::DATA_W-1:0]  o_data_out,
    output logic [lqr_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_is_empty,
    output logic                               o_is_full
);

    import lqr_pkg::*;

    // AW addresses a slot; CW also holds the value DEPTH (tail after the last slot).
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_SWAP_RD,
        S_SWAP_WR
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [DATA_W-1:0]   r_tmp, n_tmp;

    logic                r_out_valid, n_out_valid;
    logic                r_out_ok, n_out_ok;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic                r_out_empty, n_out_empty;
    logic                r_out_full, n_out_full;

    // store interface
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr_a;
    logic [AW-1:0]       mem_raddr_b;
    logic [DATA_W-1:0]   mem_rdata_a;
    logic [DATA_W-1:0]   mem_rdata_b;

    logic                in_fire;
    logic                load_out;
    logic                res_ok;
    logic [DATA_W-1:0]   res_data;
    logic [CW-1:0]       entries;
    logic [CW-1:0]       n_entries;
    logic [CW-1:0]       tail_last;

    lqr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    // Take a request only in idle, and only when the output register is free
    // by the next edge: every request may load a result.
    assign o_ready   = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_fire   = i_valid && o_ready;
    assign entries   = r_tail - r_head;
    assign tail_last = r_tail - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_tmp       = r_tmp;
        mem_we      = 1'b0;
        mem_waddr   = r_lo[AW-1:0];
        mem_wdata   = mem_rdata_b;
        mem_raddr_a = r_head[AW-1:0];
        mem_raddr_b = tail_last[AW-1:0];
        load_out    = 1'b0;
        res_ok      = 1'b0;
        res_data    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_req'(i_req_type))
                        REQ_ENQ: begin
                            // full once the tail passes the last slot
                            if (r_tail != CW'(DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_tail[AW-1:0];
                                mem_wdata = i_data_in;
                                n_tail    = r_tail + CW'(1);
                                res_ok    = 1'b1;
                            end
                            load_out = 1'b1;
                        end
                        REQ_DEQ: begin
                            if (entries != '0) begin
                                n_head  = r_head + CW'(1);
                                n_state = S_RD;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        REQ_PEEK_HEAD: begin
                            if (entries != '0) begin
                                n_state = S_RD;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        REQ_PEEK_TAIL: begin
                            mem_raddr_a = tail_last[AW-1:0];
                            if (entries != '0) begin
                                n_state = S_RD;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        REQ_REVERSE: begin
                            // fetch the outer pair; zero or one entry is a no-op
                            if (entries > CW'(1)) begin
                                n_lo    = r_head;
                                n_hi    = tail_last;
                                n_state = S_SWAP_RD;
                            end else begin
                                res_ok   = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            n_head   = '0;
                            n_tail   = '0;
                            res_ok   = 1'b1;
                            load_out = 1'b1;
                        end
                        default: begin
                            // unused request codes: fail, state unchanged
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                // store data for dequeue or peek has arrived
                res_ok   = 1'b1;
                res_data = mem_rdata_a;
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            S_SWAP_RD: begin
                // write the upper value to the lower slot, hold the lower value
                mem_we    = 1'b1;
                mem_waddr = r_lo[AW-1:0];
                mem_wdata = mem_rdata_b;
                n_tmp     = mem_rdata_a;
                n_state   = S_SWAP_WR;
            end
            S_SWAP_WR: begin
                // finish the swap and fetch the next inner pair
                mem_we      = 1'b1;
                mem_waddr   = r_hi[AW-1:0];
                mem_wdata   = r_tmp;
                n_lo        = r_lo + CW'(1);
                n_hi        = r_hi - CW'(1);
                mem_raddr_a = n_lo[AW-1:0];
                mem_raddr_b = n_hi[AW-1:0];
                if (n_lo < n_hi) begin
                    n_state = S_SWAP_RD;
                end else begin
                    res_ok   = 1'b1;
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // entries held once this transaction is done
        n_entries = n_tail - n_head;

        // Drop the held result once taken; load a new one when ready.
        n_out_valid = r_out_valid && !i_ready;
        n_out_ok    = r_out_ok;
        n_out_data  = r_out_data;
        n_out_count = r_out_count;
        n_out_empty = r_out_empty;
        n_out_full  = r_out_full;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_ok    = res_ok;
            n_out_data  = res_data;
            n_out_count = COUNT_W'(n_entries);
            n_out_empty = (n_entries == '0);
            n_out_full  = (n_tail == CW'(DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_tmp       <= n_tmp;
        r_out_ok    <= n_out_ok;
        r_out_data  <= n_out_data;
        r_out_count <= n_out_count;
        r_out_empty <= n_out_empty;
        r_out_full  <= n_out_full;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ok       = r_out_ok;
    assign o_data_out = r_out_data;
    assign o_count    = r_out_count;
    assign o_is_empty = r_out_empty;
    assign o_is_full  = r_out_full;

    `ASSERT_CLK(a_ptr_order, i_clk, i_rst_n,
                (r_head <= r_tail) && (r_tail <= CW'(DEPTH)), "head/tail out of order")
    `ASSERT_CLK(a_busy_no_result, i_clk, i_rst_n,
                (r_state != S_IDLE) |-> !r_out_valid, "result held while busy")
    `ASSERT_CLK(a_swap_pair, i_clk, i_rst_n,
                (r_state == S_SWAP_RD) |-> (r_lo < r_hi), "swap pair crossed")
    `ASSERT_NEVER(a_rd_no_write, i_clk, i_rst_n,
                  (r_state == S_RD) && mem_we, "store write during read")

endmodule

`default_nettype wire
